>>> src/cid_pkg.sv
// Shared constants, payload structs, codes and slot arithmetic for the
// circular indexed deque. Used by circular_indexed_deque; no dependencies.
package cid_pkg;

    localparam int CAPACITY   = 64;
    localparam int WORD_WIDTH = 32;
    localparam int PTR_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_SET    = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FETCH,
        ST_MOVE,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        FRONT_KEEP,
        FRONT_BACK,
        FRONT_FWD
    } front_op_t;

    typedef enum logic [1:0] {
        CNT_KEEP,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic [1:0]        opcode;
        logic signed [7:0] position;
        logic [31:0]       data_in;
    } cmd_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [1:0]  status;
        logic [6:0]  count;
    } res_t;

    // Work plan for one operation, settled in the decode cycle.
    typedef struct packed {
        status_t   status;
        logic      capture;
        logic      wr_en;
        front_op_t front_op;
        cnt_op_t   cnt_op;
        logic      dir_up;
    } plan_t;

    function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] ofs);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= (PTR_W+1)'(CAPACITY))
            sum = sum - (PTR_W+1)'(CAPACITY);
        return sum[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(CAPACITY - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] s);
        return (s == '0) ? PTR_W'(CAPACITY - 1) : s - 1'b1;
    endfunction

endpackage

>>> src/cid_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module cid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/circular_indexed_deque.sv
// Top level of the circular indexed deque: sequencer, decode and shift engine.
// Depends on cid_pkg and on cid_ram for the word store.
//
// Usage: a command beat on cmd (opcode, position, data_in) is taken when
// cmd_valid is high and cmd_stall is low. Each command produces exactly one
// result beat on res (data_out, status, count), taken when res_valid is high
// and res_stall is low. Operations are get, set (overwrite, append at the
// count, prepend at -1), insert and remove; errors are reported in status and
// leave the contents unchanged.
//
// Timing: one command occupies the engine from one taken command beat to the
// next for the decode and fetch steps, one move step per word that slides to
// open or close a gap (m words), and the finish step. The engine always moves
// the shorter side, so m is at most CAPACITY/2 - 1 (31). One word moves per
// cycle: the read for the next word overlaps the write of the previous one.
// cmd_stall stays high until the result beat is valid.
//
// The result register decouples the two sides: a new command is taken while
// an earlier result waits. If res_stall holds an earlier result, the engine
// waits at its final step and commits nothing until the result register
// frees up. Reset empties the deque (count 0, front slot 0) immediately; the
// store contents are not cleared because only live entries are ever read.
module circular_indexed_deque (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  cid_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output cid_pkg::res_t res
);

    cid_pkg::state_t state_reg, state_next;

    cid_pkg::cmd_t                         cmd_reg;
    cid_pkg::plan_t                        plan_reg;
    logic [cid_pkg::PTR_W-1:0]             moves_reg;
    logic [cid_pkg::PTR_W-1:0]             wr_slot_reg;
    logic [cid_pkg::PTR_W-1:0]             rd_slot_reg;
    logic [cid_pkg::WORD_WIDTH-1:0]        dout_reg;
    logic [cid_pkg::PTR_W-1:0]             front_reg, front_next;
    logic [cid_pkg::CNT_W-1:0]             occ_reg, occ_next;
    logic                                  res_valid_reg;
    cid_pkg::res_t                         res_reg;

    // Decode outputs.
    cid_pkg::plan_t                 plan_d;
    logic [cid_pkg::PTR_W-1:0]      start_slot_d;
    logic [cid_pkg::PTR_W-1:0]      moves_d;

    // Store port signals.
    logic                           ram_wr_en;
    logic [cid_pkg::PTR_W-1:0]      ram_wr_addr;
    logic [cid_pkg::WORD_WIDTH-1:0] ram_wr_data;
    logic [cid_pkg::PTR_W-1:0]      ram_rd_addr;
    logic [cid_pkg::WORD_WIDTH-1:0] ram_rd_data;

    logic commit;

    cid_ram #(
        .WIDTH (cid_pkg::WORD_WIDTH),
        .DEPTH (cid_pkg::CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Decode: check the command against the current count and work out where
    // the shift starts, which way it runs and how many words it moves.
    always_comb
    begin
        logic signed [8:0]          pos9;
        logic signed [8:0]          n9;
        logic [cid_pkg::CNT_W-1:0]  k;
        logic [cid_pkg::CNT_W-1:0]  half;
        logic                       full;
        logic                       do_ins;
        logic                       do_rem;
        logic                       do_ovw;
        logic                       do_get;
        logic                       ins_low;
        logic                       rem_low;

        pos9   = {cmd_reg.position[7], cmd_reg.position};
        n9     = 9'(occ_reg);
        k      = cmd_reg.position[cid_pkg::CNT_W-1:0];
        half   = occ_reg >> 1;
        full   = (occ_reg >= cid_pkg::CNT_W'(cid_pkg::CAPACITY));
        do_ins = 1'b0;
        do_rem = 1'b0;
        do_ovw = 1'b0;
        do_get = 1'b0;

        plan_d.status = cid_pkg::STAT_OK;

        unique case (cid_pkg::opcode_t'(cmd_reg.opcode)) inside
            cid_pkg::OP_GET, cid_pkg::OP_REMOVE:
            begin
                if (occ_reg == '0)
                    plan_d.status = cid_pkg::STAT_EMPTY;
                else if (pos9 < 9'sd0 || pos9 >= n9)
                    plan_d.status = cid_pkg::STAT_RANGE;
                else if (cid_pkg::opcode_t'(cmd_reg.opcode) == cid_pkg::OP_REMOVE)
                    do_rem = 1'b1;
                else
                    do_get = 1'b1;
            end
            cid_pkg::OP_SET:
            begin
                if (pos9 < -9'sd1 || pos9 > n9)
                    plan_d.status = cid_pkg::STAT_RANGE;
                else if (pos9 == -9'sd1 || pos9 == n9)
                begin
                    if (full)
                        plan_d.status = cid_pkg::STAT_FULL;
                    else
                    begin
                        do_ins = 1'b1;
                        k      = (pos9 == -9'sd1) ? '0 : occ_reg;
                    end
                end
                else
                    do_ovw = 1'b1;
            end
            cid_pkg::OP_INSERT:
            begin
                if (pos9 < 9'sd0 || pos9 > n9)
                    plan_d.status = cid_pkg::STAT_RANGE;
                else if (full)
                    plan_d.status = cid_pkg::STAT_FULL;
                else
                    do_ins = 1'b1;
            end
            default:
            begin
                plan_d.status = cid_pkg::STAT_RANGE;
            end
        endcase

        // Insert at or below the midpoint opens the gap by sliding the front side
        // back one slot; remove below the midpoint closes it from the front.
        ins_low = (k <= half);
        rem_low = (k < half);

        plan_d.capture  = do_get | do_rem | do_ovw;
        plan_d.wr_en    = do_ins | do_ovw;
        plan_d.front_op = cid_pkg::FRONT_KEEP;
        plan_d.cnt_op   = cid_pkg::CNT_KEEP;
        plan_d.dir_up   = 1'b0;
        start_slot_d    = cid_pkg::slot_add(front_reg, k[cid_pkg::PTR_W-1:0]);
        moves_d         = '0;

        if (do_ins)
        begin
            plan_d.cnt_op = cid_pkg::CNT_INC;
            if (ins_low)
            begin
                plan_d.front_op = cid_pkg::FRONT_BACK;
                plan_d.dir_up   = 1'b1;
                start_slot_d    = cid_pkg::slot_dec(front_reg);
                moves_d         = cid_pkg::PTR_W'(k);
            end
            else
            begin
                start_slot_d = cid_pkg::slot_add(front_reg, occ_reg[cid_pkg::PTR_W-1:0]);
                moves_d      = cid_pkg::PTR_W'(occ_reg - k);
            end
        end
        else if (do_rem)
        begin
            plan_d.cnt_op = cid_pkg::CNT_DEC;
            if (rem_low)
            begin
                plan_d.front_op = cid_pkg::FRONT_FWD;
                moves_d         = cid_pkg::PTR_W'(k);
            end
            else
            begin
                plan_d.dir_up = 1'b1;
                moves_d       = cid_pkg::PTR_W'(occ_reg - k - 1'b1);
            end
        end
    end

    // Sequencer next state and store port control.
    always_comb
    begin
        state_next  = state_reg;
        cmd_stall   = (state_reg != cid_pkg::ST_IDLE);
        commit      = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_slot_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = rd_slot_reg;

        unique case (state_reg)
            cid_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    state_next = cid_pkg::ST_DECODE;
            end
            cid_pkg::ST_DECODE:
            begin
                ram_rd_addr = start_slot_d;
                state_next  = cid_pkg::ST_FETCH;
            end
            cid_pkg::ST_FETCH:
            begin
                ram_rd_addr = plan_reg.dir_up ? cid_pkg::slot_inc(wr_slot_reg)
                                              : cid_pkg::slot_dec(wr_slot_reg);
                state_next  = (moves_reg == '0) ? cid_pkg::ST_FINISH : cid_pkg::ST_MOVE;
            end
            cid_pkg::ST_MOVE:
            begin
                // Write the word fetched last cycle, fetch the next source.
                ram_wr_en   = 1'b1;
                ram_rd_addr = plan_reg.dir_up ? cid_pkg::slot_inc(rd_slot_reg)
                                              : cid_pkg::slot_dec(rd_slot_reg);
                if (moves_reg == cid_pkg::PTR_W'(1))
                    state_next = cid_pkg::ST_FINISH;
            end
            cid_pkg::ST_FINISH:
            begin
                commit      = !res_valid_reg || !res_stall;
                ram_wr_en   = commit && plan_reg.wr_en;
                ram_wr_data = cmd_reg.data_in[cid_pkg::WORD_WIDTH-1:0];
                if (commit)
                    state_next = cid_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cid_pkg::ST_IDLE;
            end
        endcase
    end

    // Front pointer and count after a committed operation.
    always_comb
    begin
        front_next = front_reg;
        occ_next   = occ_reg;
        case (plan_reg.front_op)
            cid_pkg::FRONT_BACK: front_next = cid_pkg::slot_dec(front_reg);
            cid_pkg::FRONT_FWD:  front_next = cid_pkg::slot_inc(front_reg);
            default:             front_next = front_reg;
        endcase
        case (plan_reg.cnt_op)
            cid_pkg::CNT_INC: occ_next = occ_reg + 1'b1;
            cid_pkg::CNT_DEC: occ_next = occ_reg - 1'b1;
            default:          occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cid_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            occ_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                front_reg     <= front_next;
                occ_reg       <= occ_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and work registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cid_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                    cmd_reg <= cmd;
            end
            cid_pkg::ST_DECODE:
            begin
                plan_reg    <= plan_d;
                wr_slot_reg <= start_slot_d;
                moves_reg   <= (plan_d.status == cid_pkg::STAT_OK) ? moves_d : '0;
                dout_reg    <= '0;
            end
            cid_pkg::ST_FETCH:
            begin
                rd_slot_reg <= ram_rd_addr;
                if (plan_reg.capture)
                    dout_reg <= ram_rd_data;
            end
            cid_pkg::ST_MOVE:
            begin
                wr_slot_reg <= rd_slot_reg;
                rd_slot_reg <= ram_rd_addr;
                moves_reg   <= moves_reg - 1'b1;
            end
            cid_pkg::ST_FINISH:
            begin
                if (commit)
                begin
                    res_reg.data_out <= 32'(dout_reg);
                    res_reg.status   <= plan_reg.status;
                    res_reg.count    <= 7'(occ_next);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= cid_pkg::CNT_W'(cid_pkg::CAPACITY))
        else $error("occupancy above capacity");

    // A pending result always reports the current count.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.count == 7'(occ_reg))
        else $error("result count differs from occupancy");

    // A failed operation returns no data.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != cid_pkg::STAT_OK |-> res.data_out == '0)
        else $error("nonzero data on failed operation");

    // Full is only reported when the store is at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == cid_pkg::STAT_FULL |-> res.count == 7'(cid_pkg::CAPACITY))
        else $error("full status below capacity");

    // The shift loop only runs with moves outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cid_pkg::ST_MOVE |-> moves_reg != '0)
        else $error("move step with no moves left");

    // The count changes only when an operation commits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(occ_reg) |-> $past(state_reg == cid_pkg::ST_FINISH))
        else $error("occupancy changed outside commit");

endmodule
